// ===== rtl/core/lrf_pkg.sv =====
// Shared constants, register indexes and helper functions for the log record framer.
// Used by the channel interfaces and the framer top level.
// No dependencies.
package lrf_pkg;

	localparam int unsigned ID_COUNT   = 28;
	localparam int unsigned TABLE_LEN  = 28;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned BUF_DEPTH  = 4;
	localparam int unsigned BUF_CNT_W  = 3;

	localparam logic [7:0] CRC_POLY     = 8'h07;
	localparam logic [7:0] CRC_INIT     = 8'h00;
	localparam logic [7:0] RST_START    = 8'hAA;
	localparam logic [7:0] RST_MAX_SIZE = 8'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE       = 2'd0,
		CFG_START_MARKER = 2'd1,
		CFG_MAX_FRAME    = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_HEADER = 1'b0,
		KIND_ARG    = 1'b1
	} item_kind_t;

	// Argument byte count of each message ID; IDs past the table have none.
	function automatic logic [4:0] arg_bytes_of_id(input logic [4:0] id);
		logic [4:0] n;
		unique case (id)
			5'd1:    n = 5'd4;
			5'd2:    n = 5'd16;
			5'd3:    n = 5'd3;
			5'd4:    n = 5'd4;
			5'd6:    n = 5'd2;
			5'd8:    n = 5'd1;
			5'd9:    n = 5'd1;
			5'd10:   n = 5'd8;
			5'd11:   n = 5'd1;
			5'd12:   n = 5'd1;
			5'd13:   n = 5'd8;
			5'd14:   n = 5'd2;
			5'd15:   n = 5'd1;
			5'd16:   n = 5'd2;
			5'd17:   n = 5'd1;
			5'd18:   n = 5'd1;
			5'd26:   n = 5'd6;
			5'd27:   n = 5'd6;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	// One byte of an MSB-first CRC-8, no reflection and no final XOR.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/lrf_if.sv =====
// Valid/ready channel interfaces of the log record framer: input items,
// framed output bytes and register writes. Depends on lrf_pkg.
interface lrf_item_if;
	import lrf_pkg::*;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] msg_id;
	logic [7:0] arg_value;
	modport source (output valid, kind, msg_id, arg_value, input ready);
	modport sink   (input valid, kind, msg_id, arg_value, output ready);
endinterface

interface lrf_result_if;
	import lrf_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	modport source (output valid, frame_byte, frame_end, input ready);
	modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface lrf_cfg_if;
	import lrf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/log_record_framer_crc8.sv =====
// Log record framer top level: input register, framing logic and output byte buffer.
// Depends on lrf_pkg and the channel interfaces in lrf_if.sv.
//
// A header beat opens a frame of start marker, length, ID, the argument bytes
// that follow as argument beats, and a closing CRC-8 (poly 0x07, init 0) over
// the ID and the arguments. An accepted item is held in the input register and
// framed into a four-entry output buffer once that buffer is empty or sending
// its last byte; the buffer head is offered on the output port. The output
// port moves one byte per cycle while the sink is ready and sets the sustained
// rate: a header makes three or four bytes, an argument one or two, and a
// dropped item none. A new item is taken every cycle while the buffer
// is empty or sending its last byte. Register writes are taken at any time
// and should be made only while the block is idle.
module log_record_framer_crc8 (
	input  logic clk,
	input  logic arst_n,
	lrf_item_if.sink     item,
	lrf_result_if.source result,
	lrf_cfg_if.sink      cfg
);
	import lrf_pkg::*;

	// Configuration registers.
	logic       enable_q;
	logic [7:0] start_marker_q;
	logic [7:0] max_frame_q;

	// Frame state.
	logic       in_frame_q;
	logic [4:0] args_left_q;
	logic [7:0] crc_q;

	// Input register.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] msg_id_s1;
	logic [7:0] arg_s1;

	// Output buffer, head entry at index 0.
	logic [7:0]           byte_q [BUF_DEPTH];
	logic                 end_q  [BUF_DEPTH];
	logic [BUF_CNT_W-1:0] cnt_q;

	logic pop;
	logic load;

	// Framing results for the item in the input register.
	logic [7:0]           nb_byte [BUF_DEPTH];
	logic                 nb_end  [BUF_DEPTH];
	logic [BUF_CNT_W-1:0] nb_cnt;
	logic                 nx_in_frame;
	logic [4:0]           nx_args_left;
	logic [7:0]           nx_crc;

	logic       id_ok;
	logic [4:0] id_count;
	logic [7:0] id_crc;
	logic       size_ok;
	logic [7:0] arg_crc;
	logic [4:0] left_dec;

	assign cfg.ready = 1'b1;

	assign pop  = result.valid && result.ready;
	assign load = valid_s1 && ((cnt_q == '0) || ((cnt_q == BUF_CNT_W'(1)) && pop));
	assign item.ready = !valid_s1 || load;

	assign result.valid      = (cnt_q != '0);
	assign result.frame_byte = byte_q[0];
	assign result.frame_end  = end_q[0];

	always_comb begin
		id_ok    = (msg_id_s1 != 8'd0) && ({1'b0, msg_id_s1} < 9'(ID_COUNT))
			&& ({1'b0, msg_id_s1} < 9'(TABLE_LEN));
		id_count = id_ok ? arg_bytes_of_id(msg_id_s1[4:0]) : 5'd0;
		id_crc   = crc8_update(CRC_INIT, msg_id_s1);
		// Length plus one is the argument count plus four.
		size_ok  = ({4'd0, id_count} + 9'd4) <= {1'b0, max_frame_q};
		arg_crc  = crc8_update(crc_q, arg_s1);
		left_dec = args_left_q - 5'd1;
	end

	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			nb_byte[i] = 8'd0;
			nb_end[i]  = 1'b0;
		end
		nb_cnt       = '0;
		nx_in_frame  = in_frame_q;
		nx_args_left = args_left_q;
		nx_crc       = crc_q;
		if (kind_s1 == KIND_HEADER) begin
			// A header always abandons whatever frame is open.
			nx_in_frame  = 1'b0;
			nx_args_left = 5'd0;
			if (enable_q && id_ok && size_ok) begin
				nb_byte[0]   = start_marker_q;
				nb_byte[1]   = {3'd0, id_count} + 8'd3;
				nb_byte[2]   = msg_id_s1;
				nb_byte[3]   = id_crc;
				nb_end[3]    = 1'b1;
				nx_crc       = id_crc;
				nx_in_frame  = (id_count != 5'd0);
				nx_args_left = id_count;
				nb_cnt       = (id_count == 5'd0) ? BUF_CNT_W'(4) : BUF_CNT_W'(3);
			end
		end else if (in_frame_q) begin
			nb_byte[0]   = arg_s1;
			nb_byte[1]   = arg_crc;
			nb_end[1]    = 1'b1;
			nx_crc       = arg_crc;
			nx_args_left = left_dec;
			nx_in_frame  = (left_dec != 5'd0);
			nb_cnt       = (left_dec == 5'd0) ? BUF_CNT_W'(2) : BUF_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b1;
			start_marker_q <= RST_START;
			max_frame_q    <= RST_MAX_SIZE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ENABLE:       enable_q       <= cfg.data[0];
				CFG_START_MARKER: start_marker_q <= cfg.data;
				CFG_MAX_FRAME:    max_frame_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1   <= item.kind;
			msg_id_s1 <= item.msg_id;
			arg_s1    <= item.arg_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			args_left_q <= 5'd0;
			crc_q       <= CRC_INIT;
		end else if (load) begin
			in_frame_q  <= nx_in_frame;
			args_left_q <= nx_args_left;
			crc_q       <= nx_crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= nb_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - BUF_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				byte_q[i] <= nb_byte[i];
				end_q[i]  <= nb_end[i];
			end
		end else if (pop) begin
			for (int i = 0; i < BUF_DEPTH - 1; i++) begin
				byte_q[i] <= byte_q[i+1];
				end_q[i]  <= end_q[i+1];
			end
		end
	end

endmodule

// ===== rtl/core/lrf_checker.sv =====
// Port-level assertions for the log record framer, bound to its top level.
// Depends on log_record_framer_crc8 and the channel interfaces.
module lrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] frame_byte,
	input logic       frame_end,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// A stalled result beat keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(frame_byte)
			&& $stable(frame_end))
		else $error("result beat changed while stalled");

	// With nothing buffered the input side must be open.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with an empty output buffer");

	// Result bytes only appear for an item that was accepted before them.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !$past(item_valid && item_ready) |=> !result_valid)
		else $error("result beat with no item behind it");

	// Register writes are never back-pressured.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind log_record_framer_crc8 lrf_checker u_lrf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.frame_byte   (result.frame_byte),
	.frame_end    (result.frame_end),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);
